@@ hw/rtl/hprld_pkg.sv @@
`default_nettype none

package hprld_pkg;

   localparam int URL_MAX_DEFAULT = 256;

   localparam int METHOD_COUNT  = 5;
   localparam int METHOD_CHARS  = 7;
   localparam int VERSION_COUNT = 2;
   localparam int VERSION_CHARS = 8;

   // names padded to seven characters, first character in the top byte
   localparam logic [8*METHOD_CHARS-1:0] METHOD_TEXT [METHOD_COUNT] = '{
      "GET    ", "PUT    ", "POST   ", "DELETE ", "CONNECT"
   };
   localparam logic [2:0] METHOD_LEN [METHOD_COUNT] = '{3'd3, 3'd3, 3'd4, 3'd6, 3'd7};

   // bit 0 of the candidate set is HTTP/1.1, bit 1 is HTTP/1.0
   localparam logic [8*VERSION_CHARS-1:0] VERSION_TEXT [VERSION_COUNT] = '{
      "HTTP/1.1", "HTTP/1.0"
   };

   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   // parse phases of the back end
   typedef enum logic [5:0] {
      PH_METHOD  = 6'b000001,
      PH_SKIP    = 6'b000010,
      PH_FIRST   = 6'b000100,
      PH_TARGET  = 6'b001000,
      PH_VERSION = 6'b010000,
      PH_DONE    = 6'b100000
   } phase_type;

   // one classified byte, passed from front to back
   typedef struct packed {
      logic [7:0]                                 data;
      logic                                       last;
      logic [METHOD_COUNT-1:0]                    meth_hit;
      logic [METHOD_COUNT-1:0]                    meth_final;
      logic                                       is_slash;
      logic                                       is_space;
      logic [VERSION_COUNT-1:0][VERSION_CHARS-1:0] ver_hit;
   } class_type;

   typedef struct packed {
      logic       url_byte_valid;
      logic [7:0] url_byte;
      logic       verdict_valid;
      logic       detected;
      logic [2:0] method_code;
      logic [7:0] url_length;
   } rsp_item_type;

endpackage

`default_nettype wire

@@ hw/rtl/hprld_if.sv @@
`default_nettype none

interface hprld_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] payload_byte;
   logic       last_byte;

   modport source (output valid, output payload_byte, output last_byte, input ready);
   modport sink   (input valid, input payload_byte, input last_byte, output ready);
endinterface

interface hprld_rsp_if;
   logic       valid;
   logic       ready;
   logic       url_byte_valid;
   logic [7:0] url_byte;
   logic       verdict_valid;
   logic       detected;
   logic [2:0] method_code;
   logic [7:0] url_length;

   modport source (output valid, output url_byte_valid, output url_byte, output verdict_valid,
                   output detected, output method_code, output url_length, input ready);
   modport sink   (input valid, input url_byte_valid, input url_byte, input verdict_valid,
                   input detected, input method_code, input url_length, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/hprld_front.sv @@
`default_nettype none

module hprld_front (
   input  logic              clock,
   input  logic              reset,
   hprld_req_if.sink         req_if,
   output hprld_pkg::class_type item,
   output logic              item_valid,
   input  logic              item_ready
);
   import hprld_pkg::*;

   // position within the packet, saturating: only the first seven bytes matter
   logic [2:0] pos_ff;
   logic [2:0] pos_in;
   logic       accept;

   assign req_if.ready = item_ready;
   assign item_valid   = req_if.valid;
   assign accept       = req_if.valid && item_ready;

   always_comb begin
      logic [7:0] ch;
      item.data     = req_if.payload_byte;
      item.last     = req_if.last_byte;
      item.is_slash = (req_if.payload_byte == CHAR_SLASH);
      item.is_space = (req_if.payload_byte == CHAR_SPACE);
      for (int i = 0; i < METHOD_COUNT; i++) begin
         ch = 8'h00;
         for (int q = 0; q < METHOD_CHARS; q++) begin
            if (pos_ff == 3'(q)) begin
               ch = METHOD_TEXT[i][8*(METHOD_CHARS-1-q) +: 8];
            end
         end
         // a name that is already complete cannot be spoilt by later bytes
         item.meth_hit[i]   = (pos_ff < METHOD_LEN[i]) ? (req_if.payload_byte == ch) : 1'b1;
         item.meth_final[i] = (pos_ff == METHOD_LEN[i] - 3'd1);
      end
      for (int v = 0; v < VERSION_COUNT; v++) begin
         for (int k = 0; k < VERSION_CHARS; k++) begin
            item.ver_hit[v][k] =
               (req_if.payload_byte == VERSION_TEXT[v][8*(VERSION_CHARS-1-k) +: 8]);
         end
      end
   end

   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         if (req_if.last_byte) begin
            pos_in = 3'd0;
         end else if (pos_ff != 3'd7) begin
            pos_in = pos_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 3'd0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/hprld_queue.sv @@
`default_nettype none

module hprld_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  hprld_pkg::class_type wr_item,
   input  logic                 wr_valid,
   output logic                 wr_ready,
   output hprld_pkg::class_type rd_item,
   output logic                 rd_valid,
   input  logic                 rd_ready
);
   import hprld_pkg::*;

   localparam int DEPTH = 2;

   class_type  mem_ff [DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign wr_ready = (count_ff != 2'(DEPTH));
   assign rd_valid = (count_ff != 2'd0);
   assign rd_item  = mem_ff[rd_ptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(DEPTH))
      else $error("queue count beyond depth");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'(DEPTH)) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 2'd1))
      else $error("queue count missed a write");

endmodule

`default_nettype wire

@@ hw/rtl/hprld_back.sv @@
`default_nettype none

module hprld_back #(
   parameter int URL_MAX = hprld_pkg::URL_MAX_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  hprld_pkg::class_type head,
   input  logic                 head_valid,
   output logic                 head_ready,
   hprld_rsp_if.source          rsp_if
);
   import hprld_pkg::*;

   localparam int         CAP  = (URL_MAX - 1 > 255) ? 255 : URL_MAX - 1;
   localparam logic [7:0] CAP8 = 8'(CAP);

   phase_type    phase_ff, phase_in;
   logic [4:0]   cands_ff, cands_in;
   logic [2:0]   chosen_ff, chosen_in;
   logic [7:0]   count_ff, count_in;
   logic [1:0]   vcands_ff, vcands_in;
   logic [2:0]   vidx_ff, vidx_in;
   rsp_item_type out_ff, out_in;
   logic         out_valid_ff, out_valid_in;
   logic         advance, pop;

   // the output register is free when empty or being taken
   assign advance    = !out_valid_ff || rsp_if.ready;
   assign head_ready = advance;
   assign pop        = head_valid && advance;

   always_comb begin
      logic [4:0] nc;
      logic [1:0] nv;
      logic       found;
      logic [2:0] pick;

      phase_in  = phase_ff;
      cands_in  = cands_ff;
      chosen_in = chosen_ff;
      count_in  = count_ff;
      vcands_in = vcands_ff;
      vidx_in   = vidx_ff;
      out_in    = '0;
      nc        = cands_ff & head.meth_hit;
      nv        = vcands_ff & {head.ver_hit[1][vidx_ff], head.ver_hit[0][vidx_ff]};
      found     = 1'b0;
      pick      = 3'd0;

      // lowest completed method wins
      for (int i = METHOD_COUNT - 1; i >= 0; i--) begin
         if (nc[i] && head.meth_final[i]) begin
            found = 1'b1;
            pick  = 3'(i);
         end
      end

      case (phase_ff)
         PH_METHOD: begin
            cands_in = nc;
            if (found) begin
               chosen_in = pick;
               phase_in  = PH_SKIP;
            end else if (nc == 5'd0) begin
               out_in.verdict_valid = 1'b1;
               phase_in             = PH_DONE;
            end
         end
         PH_SKIP: begin
            phase_in = PH_FIRST;
         end
         PH_FIRST: begin
            if (head.is_slash) begin
               out_in.verdict_valid = 1'b1;
               phase_in             = PH_DONE;
            end else begin
               out_in.url_byte_valid = 1'b1;
               out_in.url_byte       = head.data;
               count_in              = 8'd1;
               phase_in              = PH_TARGET;
            end
         end
         PH_TARGET: begin
            if (head.is_space) begin
               vidx_in   = 3'd0;
               vcands_in = 2'b11;
               phase_in  = PH_VERSION;
            end else if (count_ff < CAP8) begin
               out_in.url_byte_valid = 1'b1;
               out_in.url_byte       = head.data;
               count_in              = count_ff + 8'd1;
            end
         end
         PH_VERSION: begin
            vcands_in = nv;
            if (nv == 2'b00) begin
               out_in.verdict_valid = 1'b1;
               phase_in             = PH_DONE;
            end else if (vidx_ff == 3'd7) begin
               out_in.verdict_valid = 1'b1;
               out_in.detected      = 1'b1;
               out_in.method_code   = chosen_ff;
               out_in.url_length    = count_ff;
               phase_in             = PH_DONE;
            end else begin
               vidx_in = vidx_ff + 3'd1;
            end
         end
         PH_DONE: begin
         end
         default: begin
            phase_in = PH_DONE;
         end
      endcase

      // end of packet: unsettled packets get a negative verdict, then start over
      if (head.last) begin
         if (phase_ff != PH_DONE) begin
            out_in.verdict_valid = 1'b1;
         end
         phase_in  = PH_METHOD;
         cands_in  = 5'h1F;
         chosen_in = 3'd0;
         count_in  = 8'd0;
         vcands_in = 2'b11;
         vidx_in   = 3'd0;
      end

      out_valid_in = advance ? head_valid : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_METHOD;
         cands_ff     <= 5'h1F;
         chosen_ff    <= 3'd0;
         count_ff     <= 8'd0;
         vcands_ff    <= 2'b11;
         vidx_ff      <= 3'd0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (pop) begin
            phase_ff  <= phase_in;
            cands_ff  <= cands_in;
            chosen_ff <= chosen_in;
            count_ff  <= count_in;
            vcands_ff <= vcands_in;
            vidx_ff   <= vidx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_ff <= out_in;
      end
   end

   assign rsp_if.valid          = out_valid_ff;
   assign rsp_if.url_byte_valid = out_ff.url_byte_valid;
   assign rsp_if.url_byte       = out_ff.url_byte;
   assign rsp_if.verdict_valid  = out_ff.verdict_valid;
   assign rsp_if.detected       = out_ff.detected;
   assign rsp_if.method_code    = out_ff.method_code;
   assign rsp_if.url_length     = out_ff.url_length;

   a_det_has_verdict: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.detected) |-> out_ff.verdict_valid)
      else $error("detection without verdict");

   a_det_has_target: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.detected) |-> (out_ff.url_length != 8'd0))
      else $error("detection with empty target");

   a_url_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ff.url_byte_valid) |-> (out_ff.url_byte == 8'd0))
      else $error("target byte not cleared");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP8)
      else $error("target count beyond cap");

endmodule

`default_nettype wire

@@ hw/rtl/http_proxy_request_line_detector_unit.sv @@
// Proxy-style HTTP request line detector.
// req_if carries one TCP payload byte per item with last_byte marking the
// end of the packet. rsp_if returns exactly one item for every byte taken:
// the target byte when it is kept, and on one item per packet a verdict
// with the method and kept target length when a proxy request line is seen.
// The front end classifies each byte against the method and version strings
// in the cycle it is taken; a two-entry queue feeds the back end, whose
// parse state machine fills the output register.
// Each byte passes through the queue and then the output register before
// its result is on rsp_if. Throughput: one item per cycle while rsp_if is
// ready, limited by the single parse step per byte in the back end.
// When rsp_if stalls the output register holds its item and the queue
// absorbs two more bytes before req_if.ready drops; nothing is lost.
// Synchronous reset empties the queue and output register and returns the
// parser to method matching at the first byte of a packet.
`default_nettype none

module http_proxy_request_line_detector_unit #(
   parameter int URL_MAX = hprld_pkg::URL_MAX_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   hprld_req_if.sink   req_if,
   hprld_rsp_if.source rsp_if
);
   import hprld_pkg::*;

   class_type front_item;
   logic      front_valid;
   logic      front_ready;
   class_type head_item;
   logic      head_valid;
   logic      head_ready;

   hprld_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .item       (front_item),
      .item_valid (front_valid),
      .item_ready (front_ready)
   );

   hprld_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_item  (front_item),
      .wr_valid (front_valid),
      .wr_ready (front_ready),
      .rd_item  (head_item),
      .rd_valid (head_valid),
      .rd_ready (head_ready)
   );

   hprld_back #(
      .URL_MAX (URL_MAX)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head_item),
      .head_valid (head_valid),
      .head_ready (head_ready),
      .rsp_if     (rsp_if)
   );

endmodule

`default_nettype wire

@@ verif/http_proxy_request_line_detector_unit_test.sv @@
`default_nettype none

module http_proxy_request_line_detector_unit_test;
   import hprld_pkg::*;

   localparam int URL_MAX     = URL_MAX_DEFAULT;
   localparam int TARGET_CAP  = (URL_MAX - 1 > 255) ? 255 : URL_MAX - 1;
   localparam int CYCLE_LIMIT = 200000;
   localparam int MAX_REPORTS = 10;

   typedef enum logic [2:0] {
      VERB_GET     = 3'd0,
      VERB_PUT     = 3'd1,
      VERB_POST    = 3'd2,
      VERB_DELETE  = 3'd3,
      VERB_CONNECT = 3'd4
   } verb_type;

   typedef logic [7:0] byte_queue_type [$];

   // names right-aligned in the vector, first character highest
   localparam logic [8*7-1:0] VERB_NAME [5] = '{"GET", "PUT", "POST", "DELETE", "CONNECT"};
   localparam int             VERB_LEN  [5] = '{3, 3, 4, 6, 7};
   localparam logic [63:0]    PROTO_NAME [2] = '{"HTTP/1.1", "HTTP/1.0"};
   localparam logic [7:0]     ASCII_SLASH = "/";
   localparam logic [7:0]     ASCII_SPACE = " ";

   logic clock = 1'b0;
   logic reset = 1'b1;

   hprld_req_if req_if ();
   hprld_rsp_if rsp_if ();

   http_proxy_request_line_detector_unit #(
      .URL_MAX(URL_MAX)
   ) i_dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_if),
      .rsp_if(rsp_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // line parser state
   logic [15:0]  line_pos;
   logic [4:0]   verb_cands;
   verb_type     verb_pick;
   phase_type    line_phase;
   logic [7:0]   url_count;
   logic [1:0]   proto_cands;
   logic [3:0]   proto_idx;
   logic         line_settled;

   rsp_item_type expected_rsp_q [$];
   int           fail_count = 0;
   int unsigned  cycle_count = 0;
   int           send_idle_pct = 0;
   int           ready_stall_pct = 0;
   int           holdoff_left = 0;

   function automatic logic [7:0] verb_char(input int v, input int p);
      return VERB_NAME[v][8*(VERB_LEN[v]-1-p) +: 8];
   endfunction

   function automatic logic [7:0] proto_char(input int which, input int k);
      return PROTO_NAME[which][8*(7-k) +: 8];
   endfunction

   function automatic void clear_line();
      line_pos     = '0;
      verb_cands   = 5'b11111;
      verb_pick    = VERB_GET;
      line_phase   = PH_METHOD;
      url_count    = '0;
      proto_cands  = 2'b11;
      proto_idx    = '0;
      line_settled = 1'b0;
   endfunction

   function automatic rsp_item_type parse_line_byte(input logic [7:0] b, input logic last);
      rsp_item_type r;
      int           pick;
      int           i;
      int           k;
      r    = '0;
      pick = -1;
      case (line_phase)
         PH_METHOD: begin
            for (i = 0; i < 5; i++)
               if (verb_cands[i] && line_pos < VERB_LEN[i] &&
                   b != verb_char(i, int'(line_pos)))
                  verb_cands[i] = 1'b0;
            // lowest-numbered complete name wins
            for (i = 4; i >= 0; i--)
               if (verb_cands[i] && VERB_LEN[i] == line_pos + 1)
                  pick = i;
            if (pick >= 0) begin
               verb_pick  = verb_type'(pick);
               line_phase = PH_SKIP;
            end else if (verb_cands == '0) begin
               line_settled    = 1'b1;
               r.verdict_valid = 1'b1;
               line_phase      = PH_DONE;
            end
         end
         PH_SKIP: line_phase = PH_FIRST;
         PH_FIRST: begin
            if (b == ASCII_SLASH) begin
               line_settled    = 1'b1;
               r.verdict_valid = 1'b1;
               line_phase      = PH_DONE;
            end else begin
               r.url_byte_valid = 1'b1;
               r.url_byte       = b;
               url_count        = 8'd1;
               line_phase       = PH_TARGET;
            end
         end
         PH_TARGET: begin
            if (b == ASCII_SPACE) begin
               proto_idx   = '0;
               proto_cands = 2'b11;
               line_phase  = PH_VERSION;
            end else if (url_count < TARGET_CAP) begin
               r.url_byte_valid = 1'b1;
               r.url_byte       = b;
               url_count++;
            end
         end
         PH_VERSION: begin
            k = int'(proto_idx[2:0]);
            for (i = 0; i < 2; i++)
               if (b != proto_char(i, k))
                  proto_cands[i] = 1'b0;
            if (proto_cands == '0) begin
               line_settled    = 1'b1;
               r.verdict_valid = 1'b1;
               line_phase      = PH_DONE;
            end else if (k == 7) begin
               line_settled    = 1'b1;
               r.verdict_valid = 1'b1;
               r.detected      = 1'b1;
               r.method_code   = verb_pick;
               r.url_length    = url_count;
               line_phase      = PH_DONE;
            end else begin
               proto_idx = 4'(k + 1);
            end
         end
         default: ;
      endcase
      if (line_pos != 16'hFFFF)
         line_pos++;
      if (last) begin
         if (!line_settled)
            r.verdict_valid = 1'b1;
         clear_line();
      end
      return r;
   endfunction

   function automatic void record_failure(input string what);
      fail_count++;
      if (fail_count <= MAX_REPORTS)
         $display("%0t: %s", $time, what);
   endfunction

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want)
         record_failure($sformatf("%s: expected %0h, got %0h", name, want, got));
   endfunction

   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_rsp_q.size() == 0) begin
            record_failure($sformatf("result item with none expected (url_byte %0h)",
                                     rsp_if.url_byte));
         end else begin
            want = expected_rsp_q.pop_front();
            check_field("url_byte_valid", 8'(want.url_byte_valid),
                        8'(rsp_if.url_byte_valid));
            check_field("url_byte", want.url_byte, rsp_if.url_byte);
            check_field("verdict_valid", 8'(want.verdict_valid), 8'(rsp_if.verdict_valid));
            check_field("detected", 8'(want.detected), 8'(rsp_if.detected));
            check_field("method_code", 8'(want.method_code), 8'(rsp_if.method_code));
            check_field("url_length", want.url_length, rsp_if.url_length);
         end
      end
   end

   // a long hold-off overrides the random stalls
   always @(posedge clock) begin
      if (holdoff_left > 0) begin
         rsp_if.ready <= 1'b0;
         holdoff_left <= holdoff_left - 1;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= ready_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic send_item(input logic [7:0] data, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.payload_byte <= data;
      req_if.last_byte    <= last;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      expected_rsp_q.push_back(parse_line_byte(data, last));
   endtask

   task automatic send_packet(input byte_queue_type pkt);
      int i;
      for (i = 0; i < pkt.size(); i++)
         send_item(pkt[i], i == pkt.size() - 1);
   endtask

   task automatic wait_all_results();
      req_if.valid <= 1'b0;
      while (expected_rsp_q.size() != 0)
         @(posedge clock);
      @(posedge clock);
   endtask

   function automatic byte_queue_type text_bytes(input string s);
      byte_queue_type pkt;
      int             i;
      for (i = 0; i < s.len(); i++)
         pkt.push_back(s[i]);
      return pkt;
   endfunction

   function automatic byte_queue_type request_line(input verb_type v, input int url_len,
                                                   input int proto);
      byte_queue_type pkt;
      logic [7:0]     c;
      int             i;
      for (i = 0; i < VERB_LEN[v]; i++)
         pkt.push_back(verb_char(v, i));
      // the byte after the name is not examined, so mostly a space but anything goes
      pkt.push_back(($urandom_range(7) == 0) ? 8'($urandom_range(255)) : ASCII_SPACE);
      for (i = 0; i < url_len; i++) begin
         do
            c = 8'($urandom_range(255));
         while (c == ASCII_SPACE || (i == 0 && c == ASCII_SLASH));
         pkt.push_back(c);
      end
      pkt.push_back(ASCII_SPACE);
      for (i = 0; i < 8; i++)
         pkt.push_back(proto_char(proto, i));
      repeat ($urandom_range(0, 12))
         pkt.push_back(8'($urandom_range(255)));
      return pkt;
   endfunction

   function automatic byte_queue_type random_packet();
      byte_queue_type pkt;
      verb_type       v;
      int             kind;
      int             keep;
      kind = $urandom_range(99);
      if (kind >= 90) begin
         repeat ($urandom_range(1, 30))
            pkt.push_back(8'($urandom_range(255)));
         return pkt;
      end
      v   = verb_type'($urandom_range(4));
      pkt = request_line(v, $urandom_range(1, 24), $urandom_range(1));
      if (kind >= 85) begin
         pkt[VERB_LEN[v] + 1] = ASCII_SLASH;
      end else if (kind >= 75) begin
         keep = $urandom_range(1, pkt.size());
         while (pkt.size() > keep)
            void'(pkt.pop_back());
      end else if (kind >= 60) begin
         pkt[$urandom_range(0, pkt.size() - 1)] = 8'($urandom_range(255));
      end
      return pkt;
   endfunction

   task automatic test_each_method();
      send_idle_pct   = 0;
      ready_stall_pct = 0;
      send_packet(text_bytes("GET x HTTP/1.1"));
      send_packet(text_bytes("PUT y HTTP/1.0"));
      send_packet(text_bytes("POST z HTTP/1.1"));
      send_packet(text_bytes("DELETE w HTTP/1.0"));
      send_packet(text_bytes("CONNECT h:1 HTTP/1.1 tail"));
      wait_all_results();
   endtask

   task automatic test_corner_cases();
      byte_queue_type pkt;
      send_packet(text_bytes("GET /x HTTP/1.1"));
      send_packet(text_bytes("GET/h HTTP/1.1"));
      // first target byte may itself be a space
      send_packet(text_bytes("GET  a HTTP/1.1"));
      // a second space is never tried once the version fails
      send_packet(text_bytes("GET a b HTTP/1.1"));
      send_packet(text_bytes("HEAD x"));
      send_packet(text_bytes("GET a HTTP/1."));
      send_packet(text_bytes("GET a HTTP/1.2"));
      send_packet(text_bytes("CONNEC"));
      pkt = {8'hFF};
      send_packet(pkt);
      pkt = {8'h00};
      send_packet(pkt);
      wait_all_results();
   endtask

   task automatic test_target_cap();
      send_idle_pct   = 37;
      ready_stall_pct = 37;
      send_packet(request_line(verb_type'($urandom_range(4)), TARGET_CAP + 1,
                               $urandom_range(1)));
      wait_all_results();
   endtask

   task automatic test_output_holdoff();
      int n;
      send_idle_pct   = 0;
      ready_stall_pct = 0;
      @(negedge clock);
      holdoff_left = 300;
      @(posedge clock);
      for (n = 0; n < 4; n++)
         send_packet(random_packet());
      wait_all_results();
   endtask

   task automatic test_pause_until_drained();
      int n;
      send_idle_pct   = 0;
      ready_stall_pct = 37;
      for (n = 0; n < 4; n++) begin
         send_packet(request_line(verb_type'($urandom_range(4)), $urandom_range(1, 8),
                                  $urandom_range(1)));
         wait_all_results();
      end
   endtask

   task automatic run_random_traffic(input int idle_pct, input int stall_pct,
                                     input int item_budget);
      byte_queue_type pkt;
      int             sent;
      send_idle_pct   = idle_pct;
      ready_stall_pct = stall_pct;
      sent = 0;
      while (sent < item_budget) begin
         pkt = random_packet();
         send_packet(pkt);
         sent += pkt.size();
      end
      wait_all_results();
   endtask

   initial begin
      req_if.valid        = 1'b0;
      req_if.payload_byte = '0;
      req_if.last_byte    = 1'b0;
      rsp_if.ready        = 1'b0;
      clear_line();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_each_method();
      test_corner_cases();
      test_target_cap();
      test_output_holdoff();
      test_pause_until_drained();
      run_random_traffic(0, 0, 300);
      run_random_traffic(88, 0, 300);
      run_random_traffic(0, 88, 300);
      run_random_traffic(37, 37, 300);

      repeat (20) @(posedge clock);
      if (fail_count == 0 && expected_rsp_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
